[src/grid_dda_line_trace_macros.svh]
// assertion macros shared by the grid line tracer modules
`ifndef GRID_DDA_LINE_TRACE_MACROS_SVH
`define GRID_DDA_LINE_TRACE_MACROS_SVH

// expression must hold at every clock edge out of reset
`define GDL_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define GDL_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[src/gdl_pkg.sv]
// shared constants, types and helpers of the grid line tracer
package gdl_pkg;

	localparam int GRID_SIDE     = 32;
	localparam int FRACTION_BITS = 16;

	localparam int COORD_W   = 5;
	localparam int COLOR_W   = 24;
	localparam int TILE_W    = 7;
	localparam int PIX_W     = 11;
	localparam int PIX_MAX   = 2047;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [TILE_W-1:0] TILE_RESET = TILE_W'(50);

	// register index taken from the word address
	localparam logic REG_TILE_PIXELS = 1'b0;

	// item modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_TRACE = 1'b1;

	localparam int MAP_DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W    = $clog2(MAP_DEPTH);
	localparam int INT_W     = COORD_W + 1;
	localparam int POS_W     = FRACTION_BITS + COORD_W + 2;
	localparam int INC_W     = FRACTION_BITS + 2;
	localparam int NUM_W     = COORD_W + FRACTION_BITS + 1;
	localparam int PROD_W    = POS_W - 1 + TILE_W;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_EVAL,
		ST_MARK
	} gdl_state_t;

	// one classified item as it waits in the queue
	typedef struct packed {
		logic               trace;
		logic               load_ok;
		logic [ADDR_W-1:0]  load_addr;
		logic               load_wall;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic               neg_x;
		logic               neg_y;
		logic [COORD_W-1:0] abs_x;
		logic [COORD_W-1:0] abs_y;
		logic [COORD_W-1:0] step;
		logic [COLOR_W-1:0] color;
	} gdl_item_t;

	typedef struct packed {
		logic               start;
		logic [COORD_W-1:0] step;
		logic [COORD_W-1:0] abs_x;
		logic [COORD_W-1:0] abs_y;
		logic               neg_x;
		logic               neg_y;
	} gdl_div_req_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [COLOR_W-1:0] color;
		logic               pixel_valid;
		logic               hit_wall;
		logic               last;
	} gdl_result_t;

	// row-major cell address, both coordinates already inside the grid
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [INT_W-1:0] y,
			input logic [INT_W-1:0] x);
		int lin;
		lin = int'(y) * GRID_SIDE + int'(x);
		return ADDR_W'(lin);
	endfunction

endpackage

[src/grid_dda_line_trace.sv]
// top level of the grid line tracer: apb register, front queue and walk engine
// grid_dda_line_trace keeps a GRID_SIDE x GRID_SIDE wall map in a ram and
// traces dda lines across it. a mode 0 transfer writes one wall bit (cells
// off the grid are ignored) and gives no result. a mode 1 transfer walks from
// the start cell to the end cell in max(|dx|,|dy|)+1 points using signed
// fixed point increments with FRACTION_BITS fraction bits, rounded toward
// plus infinity; each open point comes out as a pixel scaled by
// tile_pixels (saturated at 2047), the walk stops at the first wall or
// off-grid cell, and every trace ends with one marker result (last = 1,
// hit_wall tells whether a wall stopped it). after reset a clearing pass
// zeroes the map, one cell a cycle; in_ready stays low during the pass
// while register writes still go through. items enter a two-deep queue at
// up to one per cycle; the back end writes a load into the map in the
// cycle it pops it, while a trace leaves the queue, runs the two
// increment divisions (22 quotient bits, one per cycle, then the quotients
// are taken; skipped when start equals end), then passes each visited
// point through a check state (map read and scale multiply) and an eval
// state (wall test and emit), and ends in a mark state for the marker.
// tile_pixels lives at byte address 0, reset 50, and should only be
// written while the block is idle.
module grid_dda_line_trace
	import gdl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// apb register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// item input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [COORD_W-1:0] cell_x,
	input  logic [COORD_W-1:0] cell_y,
	input  logic               cell_wall,
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] end_x,
	input  logic [COORD_W-1:0] end_y,
	input  logic [COLOR_W-1:0] color,
	// result output
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   pixel_x,
	output logic [PIX_W-1:0]   pixel_y,
	output logic [COLOR_W-1:0] pixel_color,
	output logic               pixel_valid,
	output logic               hit_wall,
	output logic               last
);

	logic [TILE_W-1:0] tile_q;
	logic              cfg_wr;
	logic              clear_busy;
	logic              head_valid;
	gdl_item_t         head;
	logic              pop;
	gdl_result_t       result;

	// register write lands on the access cycle; word index from paddr bit 2
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_q <= TILE_RESET;
		end else if (cfg_wr && (paddr[2] == REG_TILE_PIXELS)) begin
			tile_q <= pwdata[TILE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_TILE_PIXELS) ? PDATA_W'(tile_q) : '0;

	// front: takes transfers, classifies them and queues them
	gdl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_wall  (cell_wall),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.color      (color),
		.hold       (clear_busy),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// back: map clear, loads, increment division and the walk
	gdl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tile_pixels (tile_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.clear_busy  (clear_busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result      (result)
	);

	assign pixel_x     = result.pixel_x;
	assign pixel_y     = result.pixel_y;
	assign pixel_color = result.color;
	assign pixel_valid = result.pixel_valid;
	assign hit_wall    = result.hit_wall;
	assign last        = result.last;

endmodule

[src/gdl_ram.sv]
// generic simple dual-port ram with registered read
module gdl_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/gdl_div.sv]
// two-lane restoring divider for the x and y increments
`include "grid_dda_line_trace_macros.svh"

module gdl_div
	import gdl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  gdl_div_req_t            req,
	output logic                    done,
	output logic signed [INC_W-1:0] inc_x,
	output logic signed [INC_W-1:0] inc_y
);

	localparam int CNT_W = $clog2(NUM_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   num_x_q;
	logic [NUM_W-1:0]   num_y_q;
	logic [COORD_W-1:0] rem_x_q;
	logic [COORD_W-1:0] rem_y_q;
	logic [COORD_W-1:0] step_q;
	logic               neg_x_q;
	logic               neg_y_q;

	logic [NUM_W-1:0]   load_x;
	logic [NUM_W-1:0]   load_y;
	logic [COORD_W+NUM_W-1:0] nxt_x;
	logic [COORD_W+NUM_W-1:0] nxt_y;
	logic [INC_W-2:0]   quo_x;
	logic [INC_W-2:0]   quo_y;

	// one quotient bit: returns {remainder, shifted numerator with new bit}
	function automatic logic [COORD_W+NUM_W-1:0] div_iter(input logic [NUM_W-1:0] num,
			input logic [COORD_W-1:0] rem, input logic [COORD_W-1:0] dvs);
		logic [COORD_W:0]   trial;
		logic [COORD_W-1:0] rem_n;
		logic               qbit;
		trial = {rem, num[NUM_W-1]};
		if (trial >= {1'b0, dvs}) begin
			rem_n = COORD_W'(trial - {1'b0, dvs});
			qbit  = 1'b1;
		end else begin
			rem_n = trial[COORD_W-1:0];
			qbit  = 1'b0;
		end
		return {rem_n, num[NUM_W-2:0], qbit};
	endfunction

	// positive lanes round up, negative lanes truncate the magnitude
	always_comb begin
		load_x = NUM_W'({req.abs_x, {FRACTION_BITS{1'b0}}});
		load_y = NUM_W'({req.abs_y, {FRACTION_BITS{1'b0}}});
		if (!req.neg_x) begin
			load_x = load_x + NUM_W'(req.step) - NUM_W'(1);
		end
		if (!req.neg_y) begin
			load_y = load_y + NUM_W'(req.step) - NUM_W'(1);
		end
		nxt_x = div_iter(num_x_q, rem_x_q, step_q);
		nxt_y = div_iter(num_y_q, rem_y_q, step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_x_q <= load_x;
			num_y_q <= load_y;
			rem_x_q <= '0;
			rem_y_q <= '0;
			step_q  <= req.step;
			neg_x_q <= req.neg_x;
			neg_y_q <= req.neg_y;
		end else if (busy_q) begin
			{rem_x_q, num_x_q} <= nxt_x;
			{rem_y_q, num_y_q} <= nxt_y;
		end
	end

	assign quo_x = num_x_q[INC_W-2:0];
	assign quo_y = num_y_q[INC_W-2:0];
	assign inc_x = neg_x_q ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
	assign inc_y = neg_y_q ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
	assign done  = done_q;

	`GDL_ASSERT_IMPLY(a_div_no_restart, busy_q, !req.start, "divider restarted while busy")

endmodule

[src/gdl_front.sv]
// input acceptance, item classification and the front-to-back queue
`include "grid_dda_line_trace_macros.svh"

module gdl_front
	import gdl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [COORD_W-1:0] cell_x,
	input  logic [COORD_W-1:0] cell_y,
	input  logic               cell_wall,
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] end_x,
	input  logic [COORD_W-1:0] end_y,
	input  logic [COLOR_W-1:0] color,
	input  logic               hold,
	output logic               head_valid,
	output gdl_item_t          head,
	input  logic               pop
);

	gdl_item_t         item;
	gdl_item_t         queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;

	logic signed [COORD_W:0] dx;
	logic signed [COORD_W:0] dy;
	logic [COORD_W-1:0]      adx;
	logic [COORD_W-1:0]      ady;

	always_comb begin
		dx  = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
		dy  = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
		adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
		ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

		item.trace     = (mode == MODE_TRACE);
		item.load_ok   = ((INT_W+1)'(cell_x) < (INT_W+1)'(GRID_SIDE)) &&
			((INT_W+1)'(cell_y) < (INT_W+1)'(GRID_SIDE));
		item.load_addr = cell_addr(INT_W'(cell_y), INT_W'(cell_x));
		item.load_wall = cell_wall;
		item.start_x   = start_x;
		item.start_y   = start_y;
		item.neg_x     = dx[COORD_W];
		item.neg_y     = dy[COORD_W];
		item.abs_x     = adx;
		item.abs_y     = ady;
		item.step      = (adx > ady) ? adx : ady;
		item.color     = color;
	end

	assign in_ready   = (count_q != (QPTR_W+1)'(QDEPTH)) && !hold;
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != '0);
	assign head       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= item;
		end
	end

	`GDL_ASSERT_IMPLY(a_pop_not_empty, pop, count_q != '0, "queue popped while empty")
	`GDL_ASSERT_ALWAYS(a_count_bound, count_q <= (QPTR_W+1)'(QDEPTH), "queue count overflow")

endmodule

[src/gdl_back.sv]
// map clearing, wall loads and the dda walk with the output register
`include "grid_dda_line_trace_macros.svh"

module gdl_back
	import gdl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TILE_W-1:0] tile_pixels,
	input  logic              head_valid,
	input  gdl_item_t         head,
	output logic              pop,
	output logic              clear_busy,
	output logic              out_valid,
	input  logic              out_ready,
	output gdl_result_t       result
);

	gdl_state_t state_q;
	gdl_state_t state_d;

	logic [ADDR_W-1:0]       clr_q;
	logic                    out_valid_q;
	gdl_result_t             result_q;
	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic signed [INC_W-1:0] inc_x_q;
	logic signed [INC_W-1:0] inc_y_q;
	logic [COORD_W-1:0]      cnt_q;
	logic [COORD_W-1:0]      step_q;
	logic [COLOR_W-1:0]      color_q;
	logic                    wall_q;
	logic [PROD_W-1:0]       prod_x_s1;
	logic [PROD_W-1:0]       prod_y_s1;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic              ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic              rd_wall;

	gdl_div_req_t            div_req;
	logic                    div_done;
	logic signed [INC_W-1:0] div_inc_x;
	logic signed [INC_W-1:0] div_inc_y;

	logic              out_free;
	logic              emit_pix;
	logic              emit_mark;
	logic              trace_go;
	logic [INT_W-1:0]  cx;
	logic [INT_W-1:0]  cy;
	logic              off_grid;

	gdl_ram #(
		.WIDTH(1),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_wall)
	);

	gdl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.inc_x  (div_inc_x),
		.inc_y  (div_inc_y)
	);

	function automatic logic [PIX_W-1:0] pix_sat(input logic [PROD_W-1:0] prod);
		logic [PROD_W-FRACTION_BITS-1:0] whole;
		whole = prod[PROD_W-1:FRACTION_BITS];
		if (whole > (PROD_W-FRACTION_BITS)'(PIX_MAX)) begin
			return PIX_W'(PIX_MAX);
		end
		return whole[PIX_W-1:0];
	endfunction

	assign cx       = pos_x_q[POS_W-2:FRACTION_BITS];
	assign cy       = pos_y_q[POS_W-2:FRACTION_BITS];
	assign off_grid = pos_x_q[POS_W-1] || pos_y_q[POS_W-1] ||
		({1'b0, cx} >= (INT_W+1)'(GRID_SIDE)) || ({1'b0, cy} >= (INT_W+1)'(GRID_SIDE));
	assign out_free = !out_valid_q || out_ready;
	assign trace_go = head_valid && head.trace;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(MAP_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (trace_go) begin
					state_d = (head.step == '0) ? ST_CHECK : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = off_grid ? ST_MARK : ST_EVAL;
			end
			ST_EVAL: begin
				if (rd_wall) begin
					state_d = ST_MARK;
				end else if (out_free) begin
					state_d = (cnt_q == step_q) ? ST_MARK : ST_CHECK;
				end
			end
			ST_MARK: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ram_we        = 1'b0;
		ram_waddr     = clr_q;
		ram_wdata     = 1'b0;
		ram_re        = 1'b0;
		ram_raddr     = cell_addr(cy, cx);
		pop           = 1'b0;
		emit_pix      = 1'b0;
		emit_mark     = 1'b0;
		div_req.start = 1'b0;
		div_req.step  = head.step;
		div_req.abs_x = head.abs_x;
		div_req.abs_y = head.abs_y;
		div_req.neg_x = head.neg_x;
		div_req.neg_y = head.neg_y;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				pop = head_valid;
				if (head_valid && !head.trace && head.load_ok) begin
					ram_we    = 1'b1;
					ram_waddr = head.load_addr;
					ram_wdata = head.load_wall;
				end
				div_req.start = trace_go && (head.step != '0);
			end
			ST_CHECK: begin
				ram_re = !off_grid;
			end
			ST_EVAL: begin
				emit_pix = !rd_wall && out_free;
			end
			ST_MARK: begin
				emit_mark = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (emit_pix || emit_mark) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (trace_go) begin
					pos_x_q <= POS_W'({head.start_x, {FRACTION_BITS{1'b0}}});
					pos_y_q <= POS_W'({head.start_y, {FRACTION_BITS{1'b0}}});
					inc_x_q <= '0;
					inc_y_q <= '0;
					cnt_q   <= '0;
					step_q  <= head.step;
					color_q <= head.color;
					wall_q  <= 1'b0;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					inc_x_q <= div_inc_x;
					inc_y_q <= div_inc_y;
				end
			end
			ST_CHECK: begin
				prod_x_s1 <= PROD_W'(pos_x_q[POS_W-2:0]) * PROD_W'(tile_pixels);
				prod_y_s1 <= PROD_W'(pos_y_q[POS_W-2:0]) * PROD_W'(tile_pixels);
				if (off_grid) begin
					wall_q <= 1'b1;
				end
			end
			ST_EVAL: begin
				if (rd_wall) begin
					wall_q <= 1'b1;
				end
				if (emit_pix) begin
					pos_x_q              <= pos_x_q + POS_W'(inc_x_q);
					pos_y_q              <= pos_y_q + POS_W'(inc_y_q);
					cnt_q                <= cnt_q + COORD_W'(1);
					result_q.pixel_x     <= pix_sat(prod_x_s1);
					result_q.pixel_y     <= pix_sat(prod_y_s1);
					result_q.color       <= color_q;
					result_q.pixel_valid <= 1'b1;
					result_q.hit_wall    <= 1'b0;
					result_q.last        <= 1'b0;
				end
			end
			ST_MARK: begin
				if (emit_mark) begin
					result_q.pixel_x     <= '0;
					result_q.pixel_y     <= '0;
					result_q.color       <= '0;
					result_q.pixel_valid <= 1'b0;
					result_q.hit_wall    <= wall_q;
					result_q.last        <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign clear_busy = (state_q == ST_CLEAR);
	assign out_valid  = out_valid_q;
	assign result     = result_q;

	`GDL_ASSERT_IMPLY(a_cnt_in_range, state_q == ST_CHECK || state_q == ST_EVAL,
		cnt_q <= step_q, "walk counter passed the step count")
	`GDL_ASSERT_IMPLY(a_div_done_state, div_done, state_q == ST_DIV,
		"divider finished outside the divide state")
	`GDL_ASSERT_IMPLY(a_no_write_in_walk, state_q == ST_CHECK || state_q == ST_EVAL,
		!ram_we, "map written during a walk")

endmodule

[tb/testbench.sv]
// self-checking testbench for the grid line tracer: wall loads, dda traces, tile register
`timescale 1ns / 100ps

module testbench;
	import gdl_pkg::*;

	// how the result of a directed row is known
	typedef enum logic [1:0] {
		CHECK_MODEL,
		CHECK_WALL_MARK,
		CHECK_LONE_PIXEL
	} check_kind_t;

	// one input item plus, for directed rows, the hand-typed outcome
	typedef struct packed {
		logic               mode;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic               wall;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic [COLOR_W-1:0] color;
		check_kind_t        chk;
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
	} stim_row_t;

	localparam int N_DIRECTED    = 23;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 26;
	// settle time after the results drain, room for trailing loads
	localparam int SETTLE_CYCLES = 150;
	// clearing pass plus ~180 items at worst case stalls, taken several times over
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [PADDR_W-1:0] TILE_ADDR = PADDR_W'({REG_TILE_PIXELS, 2'b00});

	// directed part, run with the tile size at its reset value of 50
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// zero-length lines at both grid corners: a single pixel then an open marker
		'{MODE_TRACE, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, CHECK_LONE_PIXEL, 0, 0},
		'{MODE_TRACE, 31, 31, 1, 31, 31, 31, 31, 24'h000000, CHECK_LONE_PIXEL, 1550, 1550},
		// the full diagonal and the anti-diagonal walked both ways
		'{MODE_TRACE, 0, 0, 0, 0, 0, 31, 31, 24'h123456, CHECK_MODEL, 0, 0},
		'{MODE_TRACE, 0, 0, 0, 31, 0, 0, 31, 24'hA5A5A5, CHECK_MODEL, 0, 0},
		'{MODE_TRACE, 0, 0, 0, 0, 31, 31, 0, 24'h5A5A5A, CHECK_MODEL, 0, 0},
		// shallow, steep and horizontal-left lines
		'{MODE_TRACE, 0, 0, 0, 5, 3, 20, 9, 24'hFF0000, CHECK_MODEL, 0, 0},
		'{MODE_TRACE, 0, 0, 0, 3, 20, 9, 2, 24'h00FF00, CHECK_MODEL, 0, 0},
		'{MODE_TRACE, 0, 0, 0, 17, 4, 2, 4, 24'h0000FF, CHECK_MODEL, 0, 0},
		// a wall on the start cell stops the trace before any pixel
		'{MODE_LOAD, 10, 10, 1, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0},
		'{MODE_TRACE, 0, 0, 0, 10, 10, 15, 15, 24'h00FFFF, CHECK_WALL_MARK, 0, 0},
		// same wall in the middle of a line, then cleared again
		'{MODE_TRACE, 0, 0, 0, 5, 10, 20, 10, 24'hFF00FF, CHECK_MODEL, 0, 0},
		'{MODE_LOAD, 10, 10, 0, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0},
		'{MODE_TRACE, 0, 0, 0, 5, 10, 20, 10, 24'hFF00FF, CHECK_MODEL, 0, 0},
		// wall on the far corner: the diagonal stops on its last point
		'{MODE_LOAD, 31, 31, 1, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0},
		'{MODE_TRACE, 0, 0, 0, 0, 0, 31, 31, 24'h808080, CHECK_MODEL, 0, 0},
		'{MODE_TRACE, 0, 0, 0, 31, 31, 31, 31, 24'hFFFFFF, CHECK_WALL_MARK, 0, 0},
		// load with the trace fields all set, trace with the cell fields all set
		'{MODE_LOAD, 0, 0, 1, 31, 31, 31, 31, 24'hFFFFFF, CHECK_MODEL, 0, 0},
		'{MODE_TRACE, 31, 31, 1, 0, 0, 0, 0, 24'h000000, CHECK_WALL_MARK, 0, 0},
		'{MODE_LOAD, 0, 0, 0, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0},
		'{MODE_LOAD, 31, 31, 0, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0},
		'{MODE_LOAD, 31, 0, 1, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0},
		'{MODE_TRACE, 0, 0, 0, 31, 0, 0, 0, 24'h0F0F0F, CHECK_WALL_MARK, 0, 0},
		'{MODE_LOAD, 31, 0, 0, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0}
	};

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic               mode      = MODE_LOAD;
	logic [COORD_W-1:0] cell_x    = '0;
	logic [COORD_W-1:0] cell_y    = '0;
	logic               cell_wall = 1'b0;
	logic [COORD_W-1:0] start_x   = '0;
	logic [COORD_W-1:0] start_y   = '0;
	logic [COORD_W-1:0] end_x     = '0;
	logic [COORD_W-1:0] end_y     = '0;
	logic [COLOR_W-1:0] color     = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [PIX_W-1:0]   pixel_x;
	logic [PIX_W-1:0]   pixel_y;
	logic [COLOR_W-1:0] pixel_color;
	logic               pixel_valid;
	logic               hit_wall;
	logic               last;

	// hand-typed outcome travels with the payload and is held with it
	check_kind_t        row_check = CHECK_MODEL;
	logic [PIX_W-1:0]   row_px    = '0;
	logic [PIX_W-1:0]   row_py    = '0;

	// shadow of the block: wall map, tile size and the pixels still to come out
	bit                 wall_bits [GRID_SIDE*GRID_SIDE];
	logic [TILE_W-1:0]  tile_now = TILE_RESET;
	gdl_result_t        pixel_q [$];

	int tx_idle = 32;
	int rx_idle = 78;
	int errors = 0;
	int out_count = 0;
	int cycles = 0;

	grid_dda_line_trace dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cell_wall   (cell_wall),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.color       (color),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.pixel_valid (pixel_valid),
		.hit_wall    (hit_wall),
		.last        (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_miss(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch at result %0d: %s got %0d want %0d", out_count, what, got, want);
	endtask

	function automatic gdl_result_t end_mark(input logic blocked);
		gdl_result_t m;
		m = '0;
		m.hit_wall = blocked;
		m.last = 1'b1;
		return m;
	endfunction

	// per-point increment, rounded toward plus infinity in both directions
	function automatic int slope_inc(input int d, input int steps);
		int num;
		num = d * (1 << FRACTION_BITS);
		if (num >= 0)
			return (num + steps - 1) / steps;
		return -((-num) / steps);
	endfunction

	// fixed point position to pixel, floored and saturated
	function automatic logic [PIX_W-1:0] scale_pos(input int pos);
		longint p;
		if (pos < 0)
			return '0;
		p = (longint'(pos) * longint'(tile_now)) >>> FRACTION_BITS;
		return PIX_W'(p > PIX_MAX ? PIX_MAX : p);
	endfunction

	// dda walk over the shadow map, queueing every pixel and the closing marker
	task automatic walk_line(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
			input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
			input logic [COLOR_W-1:0] rgb);
		int dx, dy, adx, ady, steps, incx, incy, px, py, cx, cy;
		logic blocked;
		gdl_result_t pix;
		dx = int'(ex) - int'(sx);
		dy = int'(ey) - int'(sy);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		steps = adx > ady ? adx : ady;
		// start equal to end: no division, a single point
		incx = steps == 0 ? 0 : slope_inc(dx, steps);
		incy = steps == 0 ? 0 : slope_inc(dy, steps);
		px = int'(sx) << FRACTION_BITS;
		py = int'(sy) << FRACTION_BITS;
		blocked = 1'b0;
		for (int i = 0; i <= steps; i++) begin
			cx = px >>> FRACTION_BITS;
			cy = py >>> FRACTION_BITS;
			// off-grid points count as walls
			if (px < 0 || py < 0 || cx >= GRID_SIDE || cy >= GRID_SIDE ||
					wall_bits[cy*GRID_SIDE + cx]) begin
				blocked = 1'b1;
				break;
			end
			pix.pixel_x = scale_pos(px);
			pix.pixel_y = scale_pos(py);
			pix.color = rgb;
			pix.pixel_valid = 1'b1;
			pix.hit_wall = 1'b0;
			pix.last = 1'b0;
			pixel_q.push_back(pix);
			px += incx;
			py += incy;
		end
		pixel_q.push_back(end_mark(blocked));
	endtask

	// everything seen at the rising edge: register writes, input and output transfers
	always @(posedge clk) begin
		gdl_result_t want;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == TILE_ADDR)
				tile_now = pwdata[TILE_W-1:0];
			if (in_valid && in_ready) begin
				if (mode == MODE_LOAD) begin
					// cells off the grid would be dropped
					if (int'(cell_x) < GRID_SIDE && int'(cell_y) < GRID_SIDE)
						wall_bits[int'(cell_y)*GRID_SIDE + int'(cell_x)] = cell_wall;
				end else begin
					case (row_check)
						CHECK_WALL_MARK: pixel_q.push_back(end_mark(1'b1));
						CHECK_LONE_PIXEL: begin
							pixel_q.push_back('{pixel_x: row_px, pixel_y: row_py, color: color,
								pixel_valid: 1'b1, hit_wall: 1'b0, last: 1'b0});
							pixel_q.push_back(end_mark(1'b0));
						end
						default: walk_line(start_x, start_y, end_x, end_y, color);
					endcase
				end
			end
			if (out_valid && out_ready) begin
				if (pixel_q.size() == 0) begin
					report_miss("result with nothing pending, last", last, 0);
				end else begin
					want = pixel_q.pop_front();
					if (pixel_x !== want.pixel_x)
						report_miss("pixel_x", pixel_x, want.pixel_x);
					if (pixel_y !== want.pixel_y)
						report_miss("pixel_y", pixel_y, want.pixel_y);
					if (pixel_color !== want.color)
						report_miss("pixel_color", pixel_color, want.color);
					if (pixel_valid !== want.pixel_valid)
						report_miss("pixel_valid", pixel_valid, want.pixel_valid);
					if (hit_wall !== want.hit_wall)
						report_miss("hit_wall", hit_wall, want.hit_wall);
					if (last !== want.last)
						report_miss("last", last, want.last);
				end
				out_count++;
			end
		end
	end

	// receiver stalls at random
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rx_idle);

	// one item on the input channel, with random gaps ahead of it
	task automatic send_item(input stim_row_t it);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= it.mode;
		cell_x    <= it.cx;
		cell_y    <= it.cy;
		cell_wall <= it.wall;
		start_x   <= it.sx;
		start_y   <= it.sy;
		end_x     <= it.ex;
		end_y     <= it.ey;
		color     <= it.color;
		row_check <= it.chk;
		row_px    <= it.px;
		row_py    <= it.py;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_tile(input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TILE_ADDR;
		pwdata  <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_tile();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= TILE_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(tile_now))
			report_miss("tile_pixels readback", prdata, tile_now);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// input idle, every pending result out, then room for trailing loads
	task automatic settle();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		stim_row_t it;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// register works during the clearing pass, input waits on in_ready
		check_tile();
		for (int r = 0; r < N_DIRECTED; r++)
			send_item(DIRECTED[r]);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: write_tile(1);
				1: write_tile(64);
				2: write_tile(0);
				3: write_tile(127);
				4: write_tile($urandom_range(64, 1));
				default: write_tile($urandom_range(127, 0));
			endcase
			check_tile();
			// idling swaps sides from phase 2 on, then stops altogether from phase 4
			if (ph == 2) begin
				tx_idle = 78;
				rx_idle = 32;
			end else if (ph == 4) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold the input until the output has fully drained
				if (ph == 2 && n == PHASE_ITEMS / 2) begin
					in_valid <= 1'b0;
					do @(negedge clk); while (pixel_q.size() != 0);
				end
				it.mode  = ($urandom_range(99) < 35) ? MODE_LOAD : MODE_TRACE;
				it.cx    = COORD_W'($urandom);
				it.cy    = COORD_W'($urandom);
				// walls favored so that traces get cut short
				it.wall  = ($urandom_range(99) < 60);
				it.sx    = COORD_W'($urandom);
				it.sy    = COORD_W'($urandom);
				it.ex    = COORD_W'($urandom);
				it.ey    = COORD_W'($urandom);
				it.color = COLOR_W'($urandom);
				if (it.mode == MODE_TRACE && $urandom_range(9) == 0) begin
					it.ex = it.sx;
					it.ey = it.sy;
				end
				it.chk = CHECK_MODEL;
				it.px  = '0;
				it.py  = '0;
				send_item(it);
			end
		end

		settle();
		if (pixel_q.size() != 0)
			report_miss("results never delivered", 0, pixel_q.size());
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
